### design/lpb_pkg.sv
// Shared types and constants for the LRU page buffer.
package lpb_pkg;

    // Default sizes of the buffer.
    localparam int DEF_MAX_PAGES    = 16;
    localparam int DEF_PAGE_ID_BITS = 32;

    // Fixed widths of the port fields.
    localparam int ID_PORT_BITS = 32;
    localparam int CAP_BITS     = 5;
    localparam int OUT_BITS     = 8;

    // Capacity after reset.
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Request kinds carried in tuser.
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } lpb_state_t;

    // Control handed from the sequencer to the cell chain.
    typedef struct packed {
        logic compare;
        logic update;
        logic clear;
    } lpb_ctrl_t;

endpackage

### design/lpb_cell.sv
// One cell of the page chain: holds one resident page and its match flag.
module lpb_cell
    import lpb_pkg::*;
#(
    parameter int KEY_W = DEF_PAGE_ID_BITS
) (
    input  logic             aclk,
    input  lpb_ctrl_t        ctrl,
    input  logic             cell_valid,
    input  logic [KEY_W-1:0] search_key,
    input  logic [KEY_W-1:0] key_in,
    input  logic             found_in,
    input  logic             hit,
    input  logic             shift_miss,
    output logic [KEY_W-1:0] key_out,
    output logic             found_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             match_reg;
    logic             match_next;
    logic             shift_en;

    // A hit shifts every cell from the newest end down to the matching one.
    assign found_out = found_in | match_reg;
    assign shift_en  = ctrl.update & ~ctrl.clear & (hit ? found_out : shift_miss);

    always_comb begin
        match_next = match_reg;
        if (ctrl.compare) begin
            match_next = cell_valid && (key_reg == search_key);
        end
        key_next = shift_en ? key_in : key_reg;
    end

    // Stored page and its match flag; cells beyond the count are never valid.
    always_ff @(posedge aclk) begin
        match_reg <= match_next;
        key_reg   <= key_next;
    end

    assign key_out = key_reg;

endmodule

### design/lpb_chain.sv
// Row of page cells, newest page in cell zero, with the resident count.
module lpb_chain
    import lpb_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int KEY_W     = DEF_PAGE_ID_BITS,
    parameter int CNT_W     = $clog2(MAX_PAGES + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lpb_ctrl_t        ctrl,
    input  logic [KEY_W-1:0] search_key,
    input  logic [CNT_W-1:0] cap_eff,
    output logic             hit,
    output logic             empty
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [MAX_PAGES:0] found_chain;
    logic [KEY_W-1:0]   key_chain [MAX_PAGES+1];

    assign found_chain[MAX_PAGES] = 1'b0;
    assign key_chain[0]           = search_key;
    assign hit                    = found_chain[0];
    assign empty                  = (count_reg == '0);

    // Cells; on a miss the first min(count+1, capacity) cells shift.
    for (genvar i = 0; i < MAX_PAGES; i++) begin : g_cell
        logic cell_valid;
        logic shift_miss;

        assign cell_valid = (CNT_W'(i) < count_reg);
        assign shift_miss = (CNT_W'(i) <= count_reg) && (CNT_W'(i) < cap_eff);

        lpb_cell #(
            .KEY_W(KEY_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_valid (cell_valid),
            .search_key (search_key),
            .key_in     (key_chain[i]),
            .found_in   (found_chain[i+1]),
            .hit        (hit),
            .shift_miss (shift_miss),
            .key_out    (key_chain[i+1]),
            .found_out  (found_chain[i])
        );
    end

    // Resident count: cleared by a clear request, grows on a miss with room.
    always_comb begin
        count_next = count_reg;
        if (ctrl.update) begin
            if (ctrl.clear) begin
                count_next = '0;
            end else if (!hit && (count_reg < cap_eff)) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

### design/lru_page_buffer_fault_check.sv
// Top level of the LRU page buffer with fault check.
//
// Requests arrive on the s_axis channel: tuser selects an access (0) or a
// clear of the whole buffer (1), tdata carries the page identifier. Each
// request produces exactly one result on m_axis, whose tdata bit 0 is the
// page fault flag (1 = page was not resident, 0 = hit or clear).
// The buffer is a row of cells, newest page first. A request is taken in the
// idle state, the cells compare in the lookup state, and the chain shifts and
// the result register loads in the update state. The block takes no new
// request until that pass is through: s_axis_tready is high only between passes.
// If the receiver stalls, the result waits in the output register and the
// following request waits in the update step until that register is free.
// page_capacity is written through cfg_wr_en/cfg_wr_data; a write is ignored
// while pages are resident. Synchronous reset empties the buffer, drops any
// pending result and sets the capacity to 16.
module lru_page_buffer_fault_check
    import lpb_pkg::*;
#(
    parameter int MAX_PAGES    = DEF_MAX_PAGES,
    parameter int PAGE_ID_BITS = DEF_PAGE_ID_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [ID_PORT_BITS-1:0] s_axis_tdata,  // [31:0] page_id
    input  logic                    s_axis_tuser,  // [0] command
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_BITS-1:0]     m_axis_tdata,  // [0] page_fault, rest zero
    input  logic                    cfg_wr_en,
    input  logic [CAP_BITS-1:0]     cfg_wr_data
);

    localparam int KEY_W = (PAGE_ID_BITS < ID_PORT_BITS) ? PAGE_ID_BITS : ID_PORT_BITS;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    lpb_state_t          state_reg;
    lpb_state_t          state_next;
    logic                cmd_reg;
    logic                cmd_next;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    key_next;
    logic [CAP_BITS-1:0] cap_reg;
    logic [CAP_BITS-1:0] cap_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic                m_fault_reg;
    logic                m_fault_next;
    logic [CNT_W-1:0]    cap_eff;
    logic                out_free;
    logic                load_out;
    logic                hit;
    logic                empty;
    lpb_ctrl_t           ctrl;

    // Capacity saturates at the number of cells.
    assign cap_eff = (CMP_W'(cap_reg) > CMP_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                           : CNT_W'(cap_reg);

    assign out_free = !m_valid_reg || m_axis_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        ctrl          = '0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_LOOKUP: begin
                ctrl.compare = 1'b1;
            end
            ST_UPDATE: begin
                load_out    = out_free;
                ctrl.update = out_free;
                ctrl.clear  = (cmd_reg == CMD_CLEAR);
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Request capture, configuration and result register.
    always_comb begin
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        cap_next     = cap_reg;
        m_valid_next = m_valid_reg;
        m_fault_next = m_fault_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_next = s_axis_tuser;
            key_next = s_axis_tdata[KEY_W-1:0];
        end
        if (cfg_wr_en && empty) begin
            cap_next = cfg_wr_data;
        end
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_fault_next = (cmd_reg == CMD_CLEAR) ? 1'b0 : !hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        m_fault_reg <= m_fault_next;
    end

    // Cell chain.
    lpb_chain #(
        .MAX_PAGES(MAX_PAGES),
        .KEY_W    (KEY_W),
        .CNT_W    (CNT_W)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .search_key (key_reg),
        .cap_eff    (cap_eff),
        .hit        (hit),
        .empty      (empty)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_BITS-1){1'b0}}, m_fault_reg};

endmodule

### tb/tb_top.sv
// Self-checking testbench for the LRU page buffer: streams requests, checks each fault flag.
module tb_top;
    import lpb_pkg::*;

    localparam int MAX_PAGES   = DEF_MAX_PAGES;
    localparam int STALL_PCT   = 31;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 6;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [ID_PORT_BITS-1:0] s_axis_tdata  = '0;
    logic                    s_axis_tuser  = CMD_ACCESS;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]     m_axis_tdata;
    logic                    cfg_wr_en     = 1'b0;
    logic [CAP_BITS-1:0]     cfg_wr_data   = '0;

    // Model of the buffer: slot 0 holds the least recently used page.
    logic [ID_PORT_BITS-1:0] resident_ids [MAX_PAGES];
    int unsigned             resident_count;
    logic [CAP_BITS-1:0]     page_capacity;

    // Fault flags still owed by the block, oldest first.
    logic                    fault_flags_due [$];
    logic                    fault_flag_head;
    int unsigned             fail_count  = 0;
    int unsigned             quiet_cycles = 0;

    // Idling switches for the two sides.
    bit                      send_gaps   = 1'b1;
    bit                      recv_stalls = 1'b1;

    lru_page_buffer_fault_check u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Capacity in use, saturated at the number of slots.
    function automatic int unsigned usable_capacity();
        return (page_capacity > MAX_PAGES) ? MAX_PAGES : page_capacity;
    endfunction

    // Applies one request to the model and returns the fault flag it should give.
    function automatic logic lru_lookup(input logic command, input logic [31:0] page_id);
        int unsigned cap;
        int          hit_slot;
        int unsigned first;
        cap = usable_capacity();
        hit_slot = -1;
        if (command == CMD_CLEAR) begin
            resident_count = 0;
            return 1'b0;
        end
        if (cap == 0)
            return 1'b1;
        for (int k = 0; k < resident_count; k++) begin
            if (hit_slot < 0 && resident_ids[k] == page_id)
                hit_slot = k;
        end
        if (hit_slot < 0 && resident_count < cap) begin
            resident_ids[resident_count] = page_id;
            resident_count++;
            return 1'b1;
        end
        // A hit moves its page to the newest end; a fault on a full buffer drops slot 0.
        first = (hit_slot < 0) ? 0 : hit_slot;
        for (int unsigned k = first; k + 1 < resident_count; k++)
            resident_ids[k] = resident_ids[k + 1];
        resident_ids[resident_count - 1] = page_id;
        return (hit_slot < 0);
    endfunction

    // Receiver: checks each result and stalls at random.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (fault_flags_due.size() == 0) begin
                $error("unexpected result: page_fault actual %0b", m_axis_tdata[0]);
                fail_count++;
            end else begin
                fault_flag_head = fault_flags_due[0];
                fault_flags_due.delete(0);
                if (m_axis_tdata[0] !== fault_flag_head) begin
                    $error("page_fault mismatch: expected %0b, actual %0b",
                           fault_flag_head, m_axis_tdata[0]);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= recv_stalls ? ($urandom_range(0, 99) >= STALL_PCT) : 1'b1;
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sends one request, with a random gap first, and records its expected flag.
    task automatic send_request(input logic command, input logic [31:0] page_id);
        logic expected_fault;
        while (send_gaps && $urandom_range(0, 99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= command;
        s_axis_tdata  <= page_id;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        expected_fault = lru_lookup(command, page_id);
        fault_flags_due.insert(fault_flags_due.size(), expected_fault);
    endtask

    // Stops sending and waits until every result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (fault_flags_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes the capacity register while the block is idle.
    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        // The block ignores the write while pages are resident.
        if (resident_count == 0)
            page_capacity = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Empties the buffer and then sets a new capacity.
    task automatic clear_and_resize(input logic [CAP_BITS-1:0] value);
        send_request(CMD_CLEAR, $urandom);
        write_capacity(value);
    endtask

    // Extreme page identifiers and a clear, at the reset capacity.
    task automatic test_extreme_ids();
        send_request(CMD_ACCESS, 32'h0000_0000);
        send_request(CMD_ACCESS, 32'hFFFF_FFFF);
        send_request(CMD_ACCESS, 32'h0000_0000);
        send_request(CMD_ACCESS, 32'hA5A5_A5A5);
        send_request(CMD_ACCESS, 32'h5A5A_5A5A);
        send_request(CMD_ACCESS, 32'hFFFF_FFFF);
        send_request(CMD_CLEAR,  32'hFFFF_FFFF);
        send_request(CMD_ACCESS, 32'h0000_0000);
    endtask

    // Small capacities, zero capacity and a write made while pages are resident.
    task automatic test_capacity_limits();
        write_capacity(5'd1);
        clear_and_resize(5'd1);
        send_request(CMD_ACCESS, 32'd7);
        send_request(CMD_ACCESS, 32'd7);
        send_request(CMD_ACCESS, 32'd8);
        send_request(CMD_ACCESS, 32'd7);
        clear_and_resize(5'd0);
        send_request(CMD_ACCESS, 32'd3);
        send_request(CMD_ACCESS, 32'd3);
        clear_and_resize(5'd2);
        send_request(CMD_ACCESS, 32'd1);
        send_request(CMD_ACCESS, 32'd2);
        send_request(CMD_ACCESS, 32'd1);
        send_request(CMD_ACCESS, 32'd3);
        send_request(CMD_ACCESS, 32'd1);
        send_request(CMD_ACCESS, 32'd2);
    endtask

    // Accesses drawn mostly from a working set a little larger than the buffer.
    task automatic run_working_set(input int unsigned count);
        logic [31:0] pool [$];
        int unsigned pool_size;
        int unsigned roll;
        pool_size = usable_capacity() + $urandom_range(0, 4);
        if (pool_size < 3)
            pool_size = 3;
        for (int unsigned k = 0; k < pool_size; k++)
            pool.insert(pool.size(), $urandom);
        if ($urandom_range(0, 3) == 0)
            pool[0] = '0;
        if ($urandom_range(0, 3) == 0)
            pool[pool_size - 1] = '1;
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_request(CMD_CLEAR, $urandom);
            else if (roll < 14)
                send_request(CMD_ACCESS, $urandom);
            else
                send_request(CMD_ACCESS, pool[$urandom_range(0, pool_size - 1)]);
        end
    endtask

    // Phases at several capacities, extremes first, with idling on both sides.
    task automatic test_random_phases();
        logic [CAP_BITS-1:0] extremes [6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd2};
        logic [CAP_BITS-1:0] cap;
        for (int phase = 0; phase < 20; phase++) begin
            if (phase < 6)
                cap = extremes[phase];
            else if ($urandom_range(0, 1) == 0)
                cap = CAP_BITS'($urandom_range(1, MAX_PAGES));
            else
                cap = CAP_BITS'($urandom_range(0, 31));
            // Now and then try a write while pages are still resident.
            if ($urandom_range(0, 2) == 0)
                write_capacity(CAP_BITS'($urandom));
            clear_and_resize(cap);
            run_working_set(80);
        end
    endtask

    // A long stretch with no idling on either side.
    task automatic test_back_to_back();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        clear_and_resize(CAP_BITS'($urandom_range(1, MAX_PAGES)));
        run_working_set(300);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // Main sequence.
    initial begin
        resident_count = 0;
        page_capacity  = CAP_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_ids();
        test_capacity_limits();
        test_random_phases();
        test_back_to_back();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
design/lpb_pkg.sv
design/lpb_cell.sv
design/lpb_chain.sv
design/lru_page_buffer_fault_check.sv
tb/tb_top.sv
